### rtl/agbl_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the angular grid bilinear lookup
package agbl_pkg;

   localparam int ANGLE_W     = 16;
   localparam int VALUE_W     = 16;
   localparam int LAT_W       = 15;
   localparam int FRAC_W      = 11;
   localparam int MAC_A_W     = 25;
   localparam int MAC_B_W     = 27;
   localparam int ACC_W       = 49;
   localparam int Y_W         = 24;
   localparam int DIV_SHIFT   = 14;
   localparam int RECIP_SHIFT = 32;
   localparam int CSR_INDEX_W = 4;
   localparam int STEP_W      = 3;

   localparam logic [FRAC_W-1:0]  STEP_UNITS = 11'd1920;
   localparam logic [ANGLE_W-1:0] HALF_TURN  = 16'd23040;
   localparam logic [ANGLE_W-1:0] FULL_TURN  = 16'd46080;
   localparam logic [LAT_W-1:0]   LAT_SIGN_SPAN = 15'h4000;
   // half of 1920 * 1920, added before the divide
   localparam logic [MAC_B_W-1:0] ROUND_HALF = 27'd1843200;
   // ceil(2^32 / 225), exact for quotients of 24-bit values
   localparam logic [MAC_A_W-1:0] RECIP_M    = 25'd19088744;

   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_LONG = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINT_LAT  = 4'd1;

   typedef enum logic [1:0] {
      KIND_GRID    = 2'd0,
      KIND_LONG_BP = 2'd1,
      KIND_LAT_BP  = 2'd2,
      KIND_QUERY   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FOLD,
      ST_SRCH_LON,
      ST_SRCH_LAT,
      ST_FRAC,
      ST_READ,
      ST_MAC,
      ST_DONE
   } state_type;

   typedef enum logic [STEP_W-1:0] {
      MS_R1_LO,
      MS_R1_HI,
      MS_R2_LO,
      MS_R2_HI,
      MS_ACC_LO,
      MS_ACC_HI,
      MS_ROUND,
      MS_RECIP
   } mac_step_type;

   typedef struct packed {
      logic en;
      logic accum;
   } mac_ctrl_type;

endpackage

### rtl/agbl_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module agbl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 91,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/agbl_mac.sv
`timescale 1ns / 1ps
// shared multiply-accumulate unit for interpolation and constant divide
module agbl_mac (
   input  logic                              clock,
   input  agbl_pkg::mac_ctrl_type            ctrl,
   input  logic [agbl_pkg::MAC_A_W-1:0]      op_a,
   input  logic [agbl_pkg::MAC_B_W-1:0]      op_b,
   output logic [agbl_pkg::ACC_W-1:0]        acc
);

   logic [agbl_pkg::MAC_A_W+agbl_pkg::MAC_B_W-1:0] product;
   logic [agbl_pkg::ACC_W-1:0]                    acc_base;
   logic [agbl_pkg::ACC_W-1:0]                    acc_in;
   logic [agbl_pkg::ACC_W-1:0]                    acc_ff;

   always_comb begin
      product  = op_a * op_b;
      acc_base = ctrl.accum ? acc_ff : '0;
      acc_in   = ctrl.en ? (acc_base + product[agbl_pkg::ACC_W-1:0]) : acc_ff;
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

### rtl/angular_grid_bilinear_lookup.sv
`timescale 1ns / 1ps
// top level of the angular grid bilinear magnitude lookup
//
// req channel: one item per transfer, tuser selects grid write, longitude
// breakpoint write, latitude breakpoint write or query. Writes return
// nothing; req_tready stays high while no query is in progress.
// rsp channel: one result per query, magnitude in tdata, avoidance flag in tuser.
// csr channel: pointing longitude (index 0) and latitude (index 1), always ready.
// A query runs through the fold, a breakpoint search of the longitude and
// latitude tables on one comparator, four grid ram reads and eight passes
// of the shared multiply-accumulate unit. The next query can be taken in the
// cycle in which the result first shows on rsp_tvalid, and not before.
// A result waiting on a stalled receiver does not block writes; a following
// query holds its result until the output register is free.
// Reset clears the control state and the pointing registers; the grid and
// breakpoint tables hold nothing defined until written.
module angular_grid_bilinear_lookup #(
   parameter int LONG_POINTS = 13,
   parameter int LAT_POINTS  = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // row_index[3:0], column_index[6:4], table_value[22:7], sun_longitude[38:23]
   input  logic [39:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // magnitude[15:0]
   output logic [15:0] rsp_tdata,
   // avoidance_zone[0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [agbl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);

   localparam int GRID_DEPTH = LONG_POINTS * LAT_POINTS;
   localparam int GRID_AW    = $clog2(GRID_DEPTH);
   localparam int LON_IW     = $clog2(LONG_POINTS);
   localparam int LAT_IW     = $clog2(LAT_POINTS);
   localparam int IDX_W      = (LON_IW > LAT_IW) ? LON_IW : LAT_IW;

   localparam int AW = agbl_pkg::ANGLE_W;
   localparam int VW = agbl_pkg::VALUE_W;
   localparam int FW = agbl_pkg::FRAC_W;

   // request fields
   agbl_pkg::kind_type req_kind;
   logic [3:0]         req_row;
   logic [2:0]         req_col;
   logic [VW-1:0]      req_value;
   logic [AW-1:0]      req_sun;
   logic               req_fire;
   logic               row_ok;
   logic               col_ok;

   // configuration
   logic [AW-1:0]                 point_long_ff, point_long_in;
   logic [agbl_pkg::LAT_W-1:0]    point_lat_ff, point_lat_in;

   // tables
   logic [AW-1:0] lon_bp_ff [LONG_POINTS];
   logic [AW-1:0] lat_bp_ff [LAT_POINTS];

   // control
   agbl_pkg::state_type        state_ff, state_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [agbl_pkg::STEP_W-1:0] step_ff, step_in;

   // query datapath
   logic [AW-1:0]               dist_ff, dist_in;
   logic [agbl_pkg::LAT_W-1:0]  dlat_ff, dlat_in;
   logic [LON_IW-1:0]           lon_lo_ff, lon_lo_in;
   logic [LAT_IW-1:0]           lat_lo_ff, lat_lo_in;
   logic [AW-1:0]               lon_base_ff, lon_base_in;
   logic [AW-1:0]               lat_base_ff, lat_base_in;
   logic [FW-1:0]               fl_ff, fl_in;
   logic [FW-1:0]               fa_ff, fa_in;
   logic [VW-1:0]               corner_ff [4];
   logic [VW-1:0]               corner_in [4];
   logic                        zero_ff, zero_in;
   logic [agbl_pkg::MAC_B_W-1:0] r1_ff, r1_in;

   // shared compare
   logic [AW-1:0] cmp_key;
   logic [AW-1:0] cmp_bp;
   logic          cmp_hit;
   logic          last_lon;
   logic          last_lat;

   logic [LON_IW-1:0] lon_hi;
   logic [LAT_IW-1:0] lat_hi;
   logic [LON_IW-1:0] rd_row;
   logic [LAT_IW-1:0] rd_col;
   logic [1:0]        cap_sel;

   // grid ram
   logic               grid_wr_en;
   logic [GRID_AW-1:0] grid_wr_addr;
   logic [GRID_AW-1:0] grid_rd_addr;
   logic [VW-1:0]      grid_rd_data;

   // shared unit
   agbl_pkg::mac_ctrl_type            mac_ctrl;
   logic [agbl_pkg::MAC_A_W-1:0]      mac_a;
   logic [agbl_pkg::MAC_B_W-1:0]      mac_b;
   logic [agbl_pkg::ACC_W-1:0]        mac_acc;

   // output register
   logic          rsp_load;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [VW-1:0] rsp_mag_ff, rsp_mag_in;
   logic          rsp_zone_ff, rsp_zone_in;

   function automatic logic [FW-1:0] step_frac(input logic [AW-1:0] v,
                                               input logic [AW-1:0] base);
      logic [AW-1:0] diff;
      diff = v - base;
      if (v <= base) begin
         return '0;
      end else if (diff > AW'(agbl_pkg::STEP_UNITS)) begin
         return agbl_pkg::STEP_UNITS;
      end else begin
         return diff[FW-1:0];
      end
   endfunction

   assign req_kind  = agbl_pkg::kind_type'(req_tuser);
   assign req_row   = req_tdata[3:0];
   assign req_col   = req_tdata[6:4];
   assign req_value = req_tdata[22:7];
   assign req_sun   = req_tdata[38:23];
   assign req_fire  = req_tvalid && req_tready;
   assign row_ok    = 6'(req_row) < 6'(LONG_POINTS);
   assign col_ok    = 6'(req_col) < 6'(LAT_POINTS);

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      point_long_in = point_long_ff;
      point_lat_in  = point_lat_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == agbl_pkg::CSR_POINT_LONG) begin
            point_long_in = csr_data;
         end else if (csr_index == agbl_pkg::CSR_POINT_LAT) begin
            point_lat_in = csr_data[agbl_pkg::LAT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_long_ff <= '0;
         point_lat_ff  <= '0;
      end else begin
         point_long_ff <= point_long_in;
         point_lat_ff  <= point_lat_in;
      end
   end

   // breakpoint tables
   always_ff @(posedge clock) begin
      if (req_fire && req_kind == agbl_pkg::KIND_LONG_BP && row_ok) begin
         lon_bp_ff[LON_IW'(req_row)] <= req_value;
      end
      if (req_fire && req_kind == agbl_pkg::KIND_LAT_BP && col_ok) begin
         lat_bp_ff[LAT_IW'(req_col)] <= req_value;
      end
   end

   // grid memory
   assign grid_wr_en   = req_fire && req_kind == agbl_pkg::KIND_GRID && row_ok && col_ok;
   assign grid_wr_addr = GRID_AW'(32'(req_row) * LAT_POINTS + 32'(req_col));

   assign lon_hi = (32'(lon_lo_ff) + 1 < LONG_POINTS) ? lon_lo_ff + LON_IW'(1) : lon_lo_ff;
   assign lat_hi = (32'(lat_lo_ff) + 1 < LAT_POINTS) ? lat_lo_ff + LAT_IW'(1) : lat_lo_ff;
   assign rd_row = step_ff[1] ? lon_hi : lon_lo_ff;
   assign rd_col = step_ff[0] ? lat_hi : lat_lo_ff;
   assign grid_rd_addr = GRID_AW'(32'(rd_row) * LAT_POINTS + 32'(rd_col));

   agbl_ram #(
      .WIDTH (VW),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (grid_wr_addr),
      .wr_data (req_value),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_data)
   );

   // shared breakpoint compare
   assign cmp_key  = (state_ff == agbl_pkg::ST_SRCH_LON) ? dist_ff : AW'(dlat_ff);
   assign cmp_bp   = (state_ff == agbl_pkg::ST_SRCH_LON) ? lon_bp_ff[idx_ff[LON_IW-1:0]]
                                                          : lat_bp_ff[idx_ff[LAT_IW-1:0]];
   assign cmp_hit  = (cmp_key >= cmp_bp) || (idx_ff == '0);
   assign last_lon = idx_ff == IDX_W'(LONG_POINTS - 1);
   assign last_lat = idx_ff == IDX_W'(LAT_POINTS - 1);
   assign cap_sel  = 2'(step_ff - agbl_pkg::STEP_W'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         agbl_pkg::ST_IDLE: begin
            if (req_fire && req_kind == agbl_pkg::KIND_QUERY) begin
               state_in = agbl_pkg::ST_FOLD;
            end
         end
         agbl_pkg::ST_FOLD: begin
            state_in = agbl_pkg::ST_SRCH_LON;
         end
         agbl_pkg::ST_SRCH_LON: begin
            if (last_lon) begin
               state_in = agbl_pkg::ST_SRCH_LAT;
            end
         end
         agbl_pkg::ST_SRCH_LAT: begin
            if (last_lat) begin
               state_in = agbl_pkg::ST_FRAC;
            end
         end
         agbl_pkg::ST_FRAC: begin
            state_in = agbl_pkg::ST_READ;
         end
         agbl_pkg::ST_READ: begin
            if (step_ff == agbl_pkg::STEP_W'(4)) begin
               state_in = agbl_pkg::ST_MAC;
            end
         end
         agbl_pkg::ST_MAC: begin
            if (agbl_pkg::mac_step_type'(step_ff) == agbl_pkg::MS_RECIP) begin
               state_in = agbl_pkg::ST_DONE;
            end
         end
         agbl_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = agbl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = agbl_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready   = state_ff == agbl_pkg::ST_IDLE;
      rsp_load     = (state_ff == agbl_pkg::ST_DONE) && (!rsp_tvalid_ff || rsp_tready);
      mac_ctrl.en  = state_ff == agbl_pkg::ST_MAC;
      mac_ctrl.accum = 1'b0;
      mac_a        = '0;
      mac_b        = '0;
      unique case (agbl_pkg::mac_step_type'(step_ff))
         agbl_pkg::MS_R1_LO: begin
            mac_a = agbl_pkg::MAC_A_W'(agbl_pkg::STEP_UNITS - fa_ff);
            mac_b = agbl_pkg::MAC_B_W'(corner_ff[0]);
         end
         agbl_pkg::MS_R1_HI: begin
            mac_a = agbl_pkg::MAC_A_W'(fa_ff);
            mac_b = agbl_pkg::MAC_B_W'(corner_ff[1]);
            mac_ctrl.accum = 1'b1;
         end
         agbl_pkg::MS_R2_LO: begin
            mac_a = agbl_pkg::MAC_A_W'(agbl_pkg::STEP_UNITS - fa_ff);
            mac_b = agbl_pkg::MAC_B_W'(corner_ff[2]);
         end
         agbl_pkg::MS_R2_HI: begin
            mac_a = agbl_pkg::MAC_A_W'(fa_ff);
            mac_b = agbl_pkg::MAC_B_W'(corner_ff[3]);
            mac_ctrl.accum = 1'b1;
         end
         agbl_pkg::MS_ACC_LO: begin
            mac_a = agbl_pkg::MAC_A_W'(fl_ff);
            mac_b = mac_acc[agbl_pkg::MAC_B_W-1:0];
         end
         agbl_pkg::MS_ACC_HI: begin
            mac_a = agbl_pkg::MAC_A_W'(agbl_pkg::STEP_UNITS - fl_ff);
            mac_b = r1_ff;
            mac_ctrl.accum = 1'b1;
         end
         agbl_pkg::MS_ROUND: begin
            mac_a = agbl_pkg::MAC_A_W'(1);
            mac_b = agbl_pkg::ROUND_HALF;
            mac_ctrl.accum = 1'b1;
         end
         agbl_pkg::MS_RECIP: begin
            mac_a = agbl_pkg::RECIP_M;
            mac_b = agbl_pkg::MAC_B_W'(mac_acc[agbl_pkg::DIV_SHIFT +: agbl_pkg::Y_W]);
         end
         default: begin
            mac_a = '0;
         end
      endcase
   end

   agbl_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .acc   (mac_acc)
   );

   // query datapath next values
   always_comb begin
      idx_in      = idx_ff;
      step_in     = step_ff;
      dist_in     = dist_ff;
      dlat_in     = dlat_ff;
      lon_lo_in   = lon_lo_ff;
      lat_lo_in   = lat_lo_ff;
      lon_base_in = lon_base_ff;
      lat_base_in = lat_base_ff;
      fl_in       = fl_ff;
      fa_in       = fa_ff;
      corner_in   = corner_ff;
      zero_in     = zero_ff;
      r1_in       = r1_ff;
      unique case (state_ff)
         agbl_pkg::ST_IDLE: begin
            idx_in  = '0;
            step_in = '0;
            dist_in = (point_long_ff >= req_sun) ? point_long_ff - req_sun
                                                 : req_sun - point_long_ff;
            dlat_in = point_lat_ff[agbl_pkg::LAT_W-1]
                    ? agbl_pkg::LAT_SIGN_SPAN - {1'b0, point_lat_ff[agbl_pkg::LAT_W-2:0]}
                    : {1'b0, point_lat_ff[agbl_pkg::LAT_W-2:0]};
         end
         agbl_pkg::ST_FOLD: begin
            if (dist_ff > agbl_pkg::HALF_TURN) begin
               dist_in = (dist_ff >= agbl_pkg::FULL_TURN) ? '0
                                                          : agbl_pkg::FULL_TURN - dist_ff;
            end
         end
         agbl_pkg::ST_SRCH_LON: begin
            if (cmp_hit) begin
               lon_lo_in   = idx_ff[LON_IW-1:0];
               lon_base_in = cmp_bp;
            end
            idx_in = last_lon ? '0 : idx_ff + IDX_W'(1);
         end
         agbl_pkg::ST_SRCH_LAT: begin
            if (cmp_hit) begin
               lat_lo_in   = idx_ff[LAT_IW-1:0];
               lat_base_in = cmp_bp;
            end
            idx_in = last_lat ? '0 : idx_ff + IDX_W'(1);
         end
         agbl_pkg::ST_FRAC: begin
            fl_in   = step_frac(dist_ff, lon_base_ff);
            fa_in   = step_frac(AW'(dlat_ff), lat_base_ff);
            zero_in = 1'b0;
            step_in = agbl_pkg::STEP_W'(1);
         end
         agbl_pkg::ST_READ: begin
            corner_in[cap_sel] = grid_rd_data;
            zero_in = zero_ff || (grid_rd_data == '0);
            step_in = (step_ff == agbl_pkg::STEP_W'(4)) ? '0 : step_ff + agbl_pkg::STEP_W'(1);
         end
         agbl_pkg::ST_MAC: begin
            if (agbl_pkg::mac_step_type'(step_ff) == agbl_pkg::MS_R2_LO) begin
               r1_in = mac_acc[agbl_pkg::MAC_B_W-1:0];
            end
            step_in = step_ff + agbl_pkg::STEP_W'(1);
         end
         agbl_pkg::ST_DONE: begin
            step_in = '0;
         end
         default: begin
            step_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= agbl_pkg::ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff     <= dist_in;
      dlat_ff     <= dlat_in;
      lon_lo_ff   <= lon_lo_in;
      lat_lo_ff   <= lat_lo_in;
      lon_base_ff <= lon_base_in;
      lat_base_ff <= lat_base_in;
      fl_ff       <= fl_in;
      fa_ff       <= fa_in;
      corner_ff   <= corner_in;
      zero_ff     <= zero_in;
      r1_ff       <= r1_in;
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_mag_in    = rsp_mag_ff;
      rsp_zone_in   = rsp_zone_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_zone_in   = zero_ff;
         if (zero_ff) begin
            rsp_mag_in = '0;
         end else if (mac_acc[agbl_pkg::ACC_W-1]) begin
            rsp_mag_in = '1;
         end else begin
            rsp_mag_in = mac_acc[agbl_pkg::RECIP_SHIFT +: VW];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_mag_ff  <= rsp_mag_in;
      rsp_zone_ff <= rsp_zone_in;
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_mag_ff;
   assign rsp_tuser[0] = rsp_zone_ff;

`ifndef SYNTHESIS
   query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == agbl_pkg::KIND_QUERY)
      |=> (state_ff == agbl_pkg::ST_FOLD))
      else $error("query transfer did not start the sequence");

   search_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == agbl_pkg::ST_SRCH_LON) |-> (idx_ff <= IDX_W'(LONG_POINTS - 1)))
      else $error("longitude search index out of range");

   frac_saturated: assert property (@(posedge clock) disable iff (reset)
      (state_ff == agbl_pkg::ST_MAC)
      |-> (fl_ff <= agbl_pkg::STEP_UNITS && fa_ff <= agbl_pkg::STEP_UNITS))
      else $error("fraction above one step");

   result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == agbl_pkg::ST_DONE))
      else $error("result raised outside the done state");

   result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == agbl_pkg::ST_DONE && rsp_tvalid && !rsp_tready)
      |=> (state_ff == agbl_pkg::ST_DONE))
      else $error("finished result left while output stalled");
`endif

endmodule
